@@ rtl/prf_pkg.sv @@
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types, codes and constants for the page frame replacement table.
// ----------------------------------------------------------------------------
`default_nettype none

package prf_pkg;

   // Defaults for the top level parameters
   localparam int FRAMES_DEFAULT    = 16;
   localparam int TIME_BITS_DEFAULT = 32;

   // Fixed field widths
   localparam int PAGE_BITS      = 8;
   localparam int FAULT_BITS     = 32;
   localparam int INDEX_OUT_BITS = 4;
   localparam int FIU_BITS       = 5;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 5;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_REPLACE_POLICY = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAMES_IN_USE  = 2'd1;

   // Function codes of an input word
   localparam logic FUNC_ACCESS = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;

   // Victim policies
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   localparam logic [FIU_BITS-1:0] FIU_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_SCAN_END,
      ST_COMMIT
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic idle;
      logic load;
      logic lookup;
      logic scan_start;
      logic scan_step;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_flush;
      logic hit_now;
      logic empty_now;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/prf_controller.sv @@
// ----------------------------------------------------------------------------
// prf_controller
// Sequencer for one word: lookup, optional victim scan, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire prf_pkg::status_type status,
   output prf_pkg::cmd_type         cmd
);
   import prf_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (status.is_flush || status.hit_now || status.empty_now) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            // last read result is compared at this edge
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/prf_datapath.sv @@
// ----------------------------------------------------------------------------
// prf_datapath
// Frame table, stamp memories, victim scan, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_datapath #(
   parameter int FRAMES    = prf_pkg::FRAMES_DEFAULT,
   parameter int TIME_BITS = prf_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire prf_pkg::cmd_type                   cmd,
   output prf_pkg::status_type                     status,
   input  wire logic                               req_func,
   input  wire logic [prf_pkg::PAGE_BITS-1:0]      req_page_number,
   input  wire logic                               replace_policy,
   input  wire logic [$clog2(FRAMES+1)-1:0]        frame_count,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_hit,
   output logic [prf_pkg::INDEX_OUT_BITS-1:0]      rsp_frame_index,
   output logic                                    rsp_evicted,
   output logic [prf_pkg::PAGE_BITS-1:0]           rsp_evicted_page,
   output logic [prf_pkg::FAULT_BITS-1:0]          rsp_fault_total
);
   import prf_pkg::*;

   localparam int IW = $clog2(FRAMES);
   localparam int NW = $clog2(FRAMES+1);

   // Held word
   logic                 func_ff;
   logic [PAGE_BITS-1:0] page_ff;

   // Frame table
   logic [FRAMES-1:0]    frame_valid_ff;
   logic [PAGE_BITS-1:0] frame_page_ff [FRAMES];
   logic [TIME_BITS-1:0] arrival_stamp_ff [FRAMES];
   logic [TIME_BITS-1:0] access_stamp_ff [FRAMES];

   // Lookup results
   logic          hit_now, empty_now;
   logic [IW-1:0] hit_idx, empty_idx;
   logic          hit_ff, empty_ff;
   logic [IW-1:0] hit_idx_ff, empty_idx_ff;

   // Victim scan
   logic [IW-1:0]        scan_ctr_ff;
   logic                 rd_vld_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic [TIME_BITS-1:0] arr_rd_ff, acc_rd_ff, rd_stamp;
   logic [TIME_BITS-1:0] best_ff;
   logic [IW-1:0]        victim_ff;

   // Counters
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [FAULT_BITS-1:0] fault_ff, fault_in;

   // Result register
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff, rsp_evicted_ff;
   logic [INDEX_OUT_BITS-1:0] rsp_frame_index_ff;
   logic [PAGE_BITS-1:0]  rsp_evicted_page_ff;
   logic [FAULT_BITS-1:0] rsp_fault_total_ff;

   logic          flush;
   logic          evict;
   logic [IW-1:0] slot;

   // Parallel match and first-empty search over the frames in use
   always_comb begin
      hit_now   = 1'b0;
      hit_idx   = '0;
      empty_now = 1'b0;
      empty_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (NW'(i) < frame_count) begin
            if (frame_valid_ff[i] && (frame_page_ff[i] == page_ff)) begin
               hit_now = 1'b1;
               hit_idx = IW'(i);
            end
            if (!frame_valid_ff[i]) begin
               empty_now = 1'b1;
               empty_idx = IW'(i);
            end
         end
      end
   end

   assign flush    = (func_ff == FUNC_FLUSH);
   assign evict    = !hit_ff && !empty_ff;
   assign slot     = hit_ff ? hit_idx_ff : (empty_ff ? empty_idx_ff : victim_ff);
   assign rd_stamp = (replace_policy == POLICY_LRU) ? acc_rd_ff : arr_rd_ff;
   assign time_in  = (time_ff == '1) ? time_ff : time_ff + 1'b1;
   assign fault_in = (hit_ff || fault_ff == '1) ? fault_ff : fault_ff + 1'b1;

   assign status.is_flush  = flush;
   assign status.hit_now   = hit_now;
   assign status.empty_now = empty_now;
   assign status.scan_last = (scan_ctr_ff == IW'(frame_count - 1'b1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         time_ff        <= '0;
         fault_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         rd_vld_ff      <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit) begin
            if (flush) begin
               frame_valid_ff <= '0;
               time_ff        <= '0;
               fault_ff       <= '0;
            end else begin
               frame_valid_ff[slot] <= 1'b1;
               time_ff              <= time_in;
               fault_ff             <= fault_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         page_ff <= req_page_number;
      end
      if (cmd.lookup) begin
         hit_ff       <= hit_now;
         hit_idx_ff   <= hit_idx;
         empty_ff     <= empty_now;
         empty_idx_ff <= empty_idx;
      end
      if (cmd.scan_start) begin
         scan_ctr_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ctr_ff <= scan_ctr_ff + 1'b1;
      end
      rd_idx_ff <= scan_ctr_ff;
      // running minimum; frame zero always opens the scan
      if (rd_vld_ff && ((rd_idx_ff == '0) || (rd_stamp < best_ff))) begin
         best_ff   <= rd_stamp;
         victim_ff <= rd_idx_ff;
      end
      if (cmd.commit && !flush && !hit_ff) begin
         frame_page_ff[slot] <= page_ff;
      end
      if (cmd.commit) begin
         if (flush) begin
            rsp_hit_ff          <= 1'b0;
            rsp_frame_index_ff  <= '0;
            rsp_evicted_ff      <= 1'b0;
            rsp_evicted_page_ff <= '0;
            rsp_fault_total_ff  <= '0;
         end else begin
            rsp_hit_ff          <= hit_ff;
            rsp_frame_index_ff  <= INDEX_OUT_BITS'(slot);
            rsp_evicted_ff      <= evict;
            rsp_evicted_page_ff <= evict ? frame_page_ff[victim_ff] : '0;
            rsp_fault_total_ff  <= fault_in;
         end
      end
   end

   // Stamp memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      arr_rd_ff <= arrival_stamp_ff[scan_ctr_ff];
      acc_rd_ff <= access_stamp_ff[scan_ctr_ff];
      if (cmd.commit && !flush) begin
         access_stamp_ff[slot] <= time_ff;
         if (!hit_ff) begin
            arrival_stamp_ff[slot] <= time_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_index  = rsp_frame_index_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_fault_total  = rsp_fault_total_ff;

endmodule

`default_nettype wire

@@ rtl/page_frame_replacement.sv @@
// ----------------------------------------------------------------------------
// page_frame_replacement
// Fully associative page frame table with FIFO or LRU victim choice.
// ----------------------------------------------------------------------------
// Each request word either accesses a page or flushes the table. An access is
// looked up against every frame in use in parallel; a hit or a fill into an
// empty frame passes through accept, lookup and commit, as does a flush. When
// every frame in use is occupied the victim is found by walking the stamp
// memories one frame per cycle through their single read port. The result
// sits in an output register, so a new word is taken while the previous
// response still waits on rsp_stall. Configuration writes are taken only
// between words (csr_ready high). Stamps saturate at their maximum, as does
// the fault total; equal stamps go to the lowest frame index.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_replacement #(
   parameter int FRAMES    = prf_pkg::FRAMES_DEFAULT,
   parameter int TIME_BITS = prf_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_func,
   input  wire logic [prf_pkg::PAGE_BITS-1:0]         req_page_number,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_hit,
   output logic [prf_pkg::INDEX_OUT_BITS-1:0]         rsp_frame_index,
   output logic                                       rsp_evicted,
   output logic [prf_pkg::PAGE_BITS-1:0]              rsp_evicted_page,
   output logic [prf_pkg::FAULT_BITS-1:0]             rsp_fault_total,
   // configuration write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [prf_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [prf_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import prf_pkg::*;

   localparam int NW = $clog2(FRAMES+1);
   localparam int CW = (NW > FIU_BITS) ? NW : FIU_BITS;

   cmd_type    cmd;
   status_type status;

   logic                replace_policy_ff;
   logic [FIU_BITS-1:0] frames_in_use_ff;
   logic [NW-1:0]       frame_count;

   // Accept words and register writes only between words
   assign req_stall = !cmd.idle;
   assign csr_ready = cmd.idle;

   // Configuration registers; writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         replace_policy_ff <= POLICY_FIFO;
         frames_in_use_ff  <= FIU_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REPLACE_POLICY: replace_policy_ff <= csr_wdata[0];
            CSR_FRAMES_IN_USE:  frames_in_use_ff  <= csr_wdata[FIU_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the frame count into one .. FRAMES
   always_comb begin
      if (frames_in_use_ff == '0) begin
         frame_count = NW'(1);
      end else if (CW'(frames_in_use_ff) > CW'(FRAMES)) begin
         frame_count = NW'(FRAMES);
      end else begin
         frame_count = NW'(frames_in_use_ff);
      end
   end

   prf_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   prf_datapath #(
      .FRAMES    (FRAMES),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_page_number  (req_page_number),
      .replace_policy   (replace_policy_ff),
      .frame_count      (frame_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_total  (rsp_fault_total)
   );

   // A response appears only after a commit
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("response raised without a commit");

   // Never overwrite a response that is still stalled
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while the response register is held");

   // A victim scan runs only when the table is full and the page is absent
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (!status.hit_now && !status.empty_now))
      else $error("victim scan with a hit or an empty frame");

   // A hit never reports an eviction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted)
      else $error("hit response reports an eviction");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page frame replacement table.
// ----------------------------------------------------------------------------
// A short directed table is walked first. It covers the first fill, a hit, a
// flush, the clamping of frames_in_use, eviction under each policy, frames
// hidden above the limit, and writes to unmapped register indexes. A run of
// random phases follows, each with its own policy and frame count. Accesses
// come mostly from a small pool of pages so that hits and evictions are
// frequent. Every response is checked field by field against a predictor of
// the frame table or the row's typed outcome, and both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import prf_pkg::*;

   localparam int FRAMES      = FRAMES_DEFAULT;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 155;
   localparam int DRAIN       = 40;      // well past the slowest word, a miss with eviction over all frames
   localparam int CYCLE_LIMIT = 400000;
   localparam int PLAN_LEN    = 28;

   // Unmapped register indexes: writes to these are dropped by the block
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic                      hit;
      logic [INDEX_OUT_BITS-1:0] frame_index;
      logic                      evicted;
      logic [PAGE_BITS-1:0]      evicted_page;
      logic [FAULT_BITS-1:0]     fault_total;
   } lookup_outcome_type;

   typedef enum logic { ROW_WORD, ROW_CSR } row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic                     func;
      logic [PAGE_BITS-1:0]     page;
      logic [CSR_IDX_BITS-1:0]  csr_idx;
      logic [CSR_DATA_BITS-1:0] csr_data;
      logic                     typed;
      lookup_outcome_type       want;
   } plan_row_type;

   localparam lookup_outcome_type SKIP = '0;

   // ---------------------------------------------------------------------------
   // Clock, reset and the block's inputs, all known from time zero
   // ---------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_func = FUNC_ACCESS;
   logic [PAGE_BITS-1:0]     req_page_number = '0;
   logic                     rsp_stall = 1'b0;
   logic                     csr_valid = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_REPLACE_POLICY;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   logic                      req_stall;
   logic                      rsp_valid;
   logic                      rsp_hit;
   logic [INDEX_OUT_BITS-1:0] rsp_frame_index;
   logic                      rsp_evicted;
   logic [PAGE_BITS-1:0]      rsp_evicted_page;
   logic [FAULT_BITS-1:0]     rsp_fault_total;
   logic                      csr_ready;

   always #6 clock = ~clock;

   page_frame_replacement DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_total  (rsp_fault_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: a private copy of the frame table and its registers
   // ---------------------------------------------------------------------------
   logic                 policy_sel = POLICY_FIFO;
   logic [FIU_BITS-1:0]  fiu_reg    = FIU_RESET;
   logic [FRAMES-1:0]    occupied   = '0;
   logic [PAGE_BITS-1:0] resident  [FRAMES];
   logic [31:0]          loaded_at [FRAMES];
   logic [31:0]          used_at   [FRAMES];
   logic [31:0]          tick   = '0;
   logic [31:0]          faults = '0;

   lookup_outcome_type outcome_q [$];   // responses still owed, oldest first
   lookup_outcome_type want_now;
   int                 err_count = 0;
   int                 cycles    = 0;
   bit                 calm      = 1'b0; // high: neither side idles

   // Effective frame count: zero counts as one, anything above the table
   // size counts as the table size
   function automatic int live_frames();
      if (fiu_reg == 0) return 1;
      if (fiu_reg > FRAMES) return FRAMES;
      return int'(fiu_reg);
   endfunction

   // Advance the frame table by one word and return the response it owes
   function automatic lookup_outcome_type table_lookup(logic f,
                                                       logic [PAGE_BITS-1:0] p);
      lookup_outcome_type o;
      int                 n;
      int                 i;
      int                 slot;
      bit                 found;
      logic [31:0]        now;
      o = '0;
      if (f == FUNC_FLUSH) begin
         occupied = '0;
         tick     = '0;
         faults   = '0;
         return o;
      end
      n     = live_frames();
      now   = tick;
      slot  = 0;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
         if (!found && occupied[i] && resident[i] == p) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         o.hit         = 1'b1;
         used_at[slot] = now;
      end else begin
         if (faults != '1) faults = faults + 1;
         // fill the lowest empty frame, else evict the oldest stamp
         for (i = 0; i < n; i++) begin
            if (!found && !occupied[i]) begin
               slot  = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            slot = 0;
            for (i = 1; i < n; i++) begin
               if (policy_sel == POLICY_LRU) begin
                  if (used_at[i] < used_at[slot]) slot = i;
               end else begin
                  if (loaded_at[i] < loaded_at[slot]) slot = i;
               end
            end
            o.evicted      = 1'b1;
            o.evicted_page = resident[slot];
         end
         occupied[slot]  = 1'b1;
         resident[slot]  = p;
         loaded_at[slot] = now;
         used_at[slot]   = now;
      end
      // the clock stops at its top value; out of reach in a run this short
      if (now != '1) tick = now + 1;
      o.frame_index = slot[INDEX_OUT_BITS-1:0];
      o.fault_total = faults;
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   // Offer one word, idling first at random. Return at the edge that takes it,
   // with valid still high, so the caller either offers the next word or drops
   // valid in that same step.
   task automatic send_word(input logic f, input logic [PAGE_BITS-1:0] p,
                            input logic typed, input lookup_outcome_type want);
      lookup_outcome_type owed;
      csr_valid <= 1'b0;
      while (!calm && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_page_number <= p;
      do @(posedge clock); while (req_stall);
      owed = table_lookup(f, p);
      if (typed) owed = want;
      outcome_q.push_back(owed);
   endtask

   // Write one register once the table has gone quiet. Leave valid high on
   // return so back-to-back writes do not drop and raise it in one step.
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_REPLACE_POLICY) policy_sel = data[0];
      else if (idx == CSR_FRAMES_IN_USE) fiu_reg = data;
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random back-pressure and the checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 10);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            $error("response word with nothing pending");
            err_count++;
         end else begin
            want_now = outcome_q.pop_front();
            if (rsp_hit !== want_now.hit) begin
               $error("hit: expected %0d, got %0d", want_now.hit, rsp_hit);
               err_count++;
            end
            if (rsp_frame_index !== want_now.frame_index) begin
               $error("frame_index: expected %0d, got %0d",
                      want_now.frame_index, rsp_frame_index);
               err_count++;
            end
            if (rsp_evicted !== want_now.evicted) begin
               $error("evicted: expected %0d, got %0d", want_now.evicted, rsp_evicted);
               err_count++;
            end
            if (rsp_evicted_page !== want_now.evicted_page) begin
               $error("evicted_page: expected %0h, got %0h",
                      want_now.evicted_page, rsp_evicted_page);
               err_count++;
            end
            if (rsp_fault_total !== want_now.fault_total) begin
               $error("fault_total: expected %0d, got %0d",
                      want_now.fault_total, rsp_fault_total);
               err_count++;
            end
         end
      end
   end

   // Watchdog: abandon a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Directed table. Typed outcomes only where they are plain; the rest go to
   // the predictor. Starts from reset: FIFO, all sixteen frames.
   // ---------------------------------------------------------------------------
   plan_row_type plan [PLAN_LEN] = '{
      // first fill, a second page, a hit, then a flush clearing everything
      '{ROW_WORD, FUNC_ACCESS, 8'h00, CSR_REPLACE_POLICY, 5'd0, 1'b1,
        '{1'b0, 4'd0, 1'b0, 8'h00, 32'd1}},
      '{ROW_WORD, FUNC_ACCESS, 8'hFF, CSR_REPLACE_POLICY, 5'd0, 1'b1,
        '{1'b0, 4'd1, 1'b0, 8'h00, 32'd2}},
      '{ROW_WORD, FUNC_ACCESS, 8'h00, CSR_REPLACE_POLICY, 5'd0, 1'b1,
        '{1'b1, 4'd0, 1'b0, 8'h00, 32'd2}},
      '{ROW_WORD, FUNC_FLUSH,  8'h5A, CSR_REPLACE_POLICY, 5'd0, 1'b1, SKIP},
      // zero frames counts as one: the second miss evicts frame zero
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_FRAMES_IN_USE,  5'd0, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'hAA, CSR_REPLACE_POLICY, 5'd0, 1'b1,
        '{1'b0, 4'd0, 1'b0, 8'h00, 32'd1}},
      '{ROW_WORD, FUNC_ACCESS, 8'h55, CSR_REPLACE_POLICY, 5'd0, 1'b1,
        '{1'b0, 4'd0, 1'b1, 8'hAA, 32'd2}},
      // two frames under LRU: the touched page survives
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_FRAMES_IN_USE,  5'd2, 1'b0, SKIP},
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_REPLACE_POLICY, 5'(POLICY_LRU), 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h55, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h12, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h55, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h34, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      // back to FIFO: the oldest arrival goes despite the recent hit
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_REPLACE_POLICY, 5'b11110, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h55, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h66, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      // park a page in frame three, hide it, then raise the limit past the top
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_FRAMES_IN_USE,  5'd4, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h10, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h11, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_FRAMES_IN_USE,  5'd1, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h77, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_FRAMES_IN_USE,  5'd31, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h11, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      // unmapped indexes must leave both registers alone
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_SPARE_LO,       5'd31, 1'b0, SKIP},
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_SPARE_HI,       5'b10101, 1'b0, SKIP},
      '{ROW_WORD, FUNC_ACCESS, 8'h77, CSR_REPLACE_POLICY, 5'd0, 1'b0, SKIP},
      '{ROW_CSR,  FUNC_ACCESS, 8'h00, CSR_FRAMES_IN_USE,  5'd16, 1'b0, SKIP},
      '{ROW_WORD, FUNC_FLUSH,  8'hFF, CSR_REPLACE_POLICY, 5'd0, 1'b1, SKIP}
   };

   // ---------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin
      int                   row;
      int                   ph;
      int                   k;
      int                   pool;
      int                   r;
      logic [PAGE_BITS-1:0] base;
      logic [PAGE_BITS-1:0] pg;
      logic [FIU_BITS-1:0]  fiu_pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < PLAN_LEN; row++) begin
         if (plan[row].kind == ROW_CSR) begin
            write_csr(plan[row].csr_idx, plan[row].csr_data);
         end else begin
            send_word(plan[row].func, plan[row].page, plan[row].typed, plan[row].want);
         end
      end

      // Random phases: the extremes of both registers come first
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       fiu_pick = 5'd1;
            1:       fiu_pick = 5'd16;
            2:       fiu_pick = 5'd0;
            3:       fiu_pick = 5'd31;
            4:       fiu_pick = 5'd2;
            default: fiu_pick = 5'($urandom_range(0, 31));
         endcase
         write_csr(CSR_REPLACE_POLICY,
                   (ph < 4) ? 5'(ph % 2) : 5'($urandom_range(0, 31)));
         write_csr(CSR_FRAMES_IN_USE, fiu_pick);
         write_csr($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                   5'($urandom_range(0, 31)));
         calm = (ph == 3);   // one long stretch with no idling on either side

         // pool a few pages wider than the table, so hits and evictions mix
         pool = live_frames() + $urandom_range(0, 3);
         base = 8'($urandom_range(0, 255));
         for (k = 0; k < PHASE_WORDS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               send_word(FUNC_FLUSH, 8'($urandom_range(0, 255)), 1'b0, SKIP);
            end else if (r < 15) begin
               send_word(FUNC_ACCESS, 8'($urandom_range(0, 255)), 1'b0, SKIP);
            end else begin
               pg = base + 8'($urandom_range(0, pool - 1));
               send_word(FUNC_ACCESS, pg, 1'b0, SKIP);
            end
         end
      end

      // Drop valid, drain every owed response, then let the block settle
      req_valid <= 1'b0;
      calm = 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
